### sv/pm4_packet_stream_parser_defines.svh
// ---------------------------------------------------------------------------
// PM4 packet stream parser: assertion macros
// Shared concurrent assertion forms. They sample on clk and are quiet in rst.
// ---------------------------------------------------------------------------
`ifndef PM4_PACKET_STREAM_PARSER_DEFINES_SVH
`define PM4_PACKET_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication
`define PM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pm4_pkg.sv
// ---------------------------------------------------------------------------
// PM4 packet stream parser: package
// Result kinds, header types and the decoded command passed front to back.
// ---------------------------------------------------------------------------
package pm4_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR     = 2'd0;
  localparam logic [1:0] KIND_REG     = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  // Header types, bits 31..30
  localparam logic [1:0] HDR_TYPE0 = 2'd0;
  localparam logic [1:0] HDR_TYPE1 = 2'd1;
  localparam logic [1:0] HDR_TYPE2 = 2'd2;
  localparam logic [1:0] HDR_TYPE3 = 2'd3;

  // Register limit after reset
  localparam logic [15:0] REG_LIMIT_RESET = 16'h5003;

  // Decoded command word; idx is the full 16-bit index before masking
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] idx;
    logic [31:0] value;
    logic [6:0]  opcode;
    logic        predicated;
    logic [13:0] pos;
    logic        last;
  } cmd_t;

endpackage

### sv/pm4_packet_stream_parser.sv
// ---------------------------------------------------------------------------
// PM4 packet stream parser
// Decodes a PM4 command stream into no-ops, register writes and payloads.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one 32-bit stream word. Every
//   accepted word yields exactly one output word on out_valid/out_ready:
//   a consumed header, a register write or a type 3 payload word.
//   cfg_we/cfg_data write the 16-bit register limit; write it only while
//   the parser is idle. Indices at or above it raise bad_index.
//   Path: an accepted word is written into the queue at the accept edge
//   and loads into the output register when the queue pops it, which
//   waits while the output holds a word that out_ready has not taken.
//   Throughput: one word per cycle, sustained while out_ready stays high.
//   The front end decodes and updates packet state in the accept cycle; the
//   queue (QUEUE_DEPTH entries) lets it run ahead of the output register.
//   When the receiver stalls, the output holds and the queue fills; in_ready
//   falls once the queue is full.
//   Reset (rst, synchronous) empties the queue, drops out_valid, returns the
//   parser to expecting a header and sets the limit to 0x5003.
// ---------------------------------------------------------------------------
`include "pm4_packet_stream_parser_defines.svh"

module pm4_packet_stream_parser
  import pm4_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [14:0] reg_index,
  output logic [31:0] value,
  output logic [6:0]  opcode,
  output logic        predicated,
  output logic [13:0] payload_pos,
  output logic        last,
  output logic        bad_index
);

  logic [15:0] reg_limit;
  logic        space;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  logic        head_valid;
  cmd_t        head_cmd;

  // Register limit
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_limit <= REG_LIMIT_RESET;
    end else if (cfg_we) begin
      reg_limit <= cfg_data;
    end
  end

  pm4_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .word     (word),
    .space    (space),
    .push     (push),
    .cmd      (push_cmd)
  );

  pm4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pm4_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .reg_limit   (reg_limit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .reg_index   (reg_index),
    .value       (value),
    .opcode      (opcode),
    .predicated  (predicated),
    .payload_pos (payload_pos),
    .last        (last),
    .bad_index   (bad_index)
  );

  // Checks
  `PM4_ASSERT_NOW(a_bad_only_reg, out_valid && bad_index, kind == KIND_REG, "bad_index off a register write")
  `PM4_ASSERT_NOW(a_reg_no_opcode, out_valid && kind == KIND_REG, opcode == 7'd0 && !predicated, "register write carries opcode")
  `PM4_ASSERT_NOW(a_hdr_pos_zero, out_valid && kind == KIND_HDR, payload_pos == 14'd0 && reg_index == 15'd0, "header with position or index")
  `PM4_ASSERT_NEXT(a_pop_shows, pop, out_valid, "popped word not presented")

endmodule

### sv/pm4_front.sv
// ---------------------------------------------------------------------------
// PM4 front end
// Accepts stream words, tracks packet state and classifies each word.
// ---------------------------------------------------------------------------
module pm4_front
  import pm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  input  logic        space,
  output logic        push,
  output cmd_t        cmd
);

  // Packet state
  logic [14:0] words_left;
  logic [31:0] held_header;
  logic [13:0] word_position;

  logic [14:0] words_left_next;
  logic [31:0] held_header_next;
  logic [13:0] word_position_next;

  logic        at_header;
  logic [1:0]  in_type;
  logic [1:0]  held_type;
  logic [14:0] hdr_len;
  logic [15:0] t0_idx;

  assign in_ready  = space;
  assign push      = in_valid && space;
  assign at_header = (words_left == 15'd0);
  assign in_type   = word[31:30];
  assign held_type = held_header[31:30];

  // Type 0 index: base plus position unless the fixed-index bit is set
  assign t0_idx = {1'b0, held_header[14:0]} +
                  (held_header[15] ? 16'd0 : {2'b00, word_position});

  // Payload length announced by a header
  always_comb begin
    if (word == 32'd0 || in_type == HDR_TYPE2) begin
      hdr_len = 15'd0;
    end else if (in_type == HDR_TYPE1) begin
      hdr_len = 15'd2;
    end else begin
      hdr_len = {1'b0, word[29:16]} + 15'd1;
    end
  end

  // Classify the incoming word
  always_comb begin
    cmd       = '0;
    cmd.value = word;
    if (at_header) begin
      cmd.kind = KIND_HDR;
      cmd.last = (hdr_len == 15'd0);
      if (in_type == HDR_TYPE3) begin
        cmd.opcode     = word[14:8];
        cmd.predicated = word[0];
      end
    end else begin
      cmd.pos  = word_position;
      cmd.last = (words_left == 15'd1);
      if (held_type == HDR_TYPE3) begin
        cmd.kind       = KIND_PAYLOAD;
        cmd.opcode     = held_header[14:8];
        cmd.predicated = held_header[0];
      end else begin
        cmd.kind = KIND_REG;
        if (held_type == HDR_TYPE1) begin
          cmd.idx = (word_position == 14'd0) ? {5'd0, held_header[10:0]}
                                             : {5'd0, held_header[21:11]};
        end else begin
          cmd.idx = t0_idx;
        end
      end
    end
  end

  // State update on each accepted word
  always_comb begin
    words_left_next    = words_left;
    held_header_next   = held_header;
    word_position_next = word_position;
    if (push) begin
      if (at_header) begin
        words_left_next    = hdr_len;
        held_header_next   = word;
        word_position_next = 14'd0;
      end else begin
        words_left_next    = words_left - 15'd1;
        word_position_next = word_position + 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left    <= 15'd0;
      held_header   <= 32'd0;
      word_position <= 14'd0;
    end else begin
      words_left    <= words_left_next;
      held_header   <= held_header_next;
      word_position <= word_position_next;
    end
  end

endmodule

### sv/pm4_queue.sv
// ---------------------------------------------------------------------------
// PM4 command queue
// Short FIFO of decoded commands between the front and back ends.
// ---------------------------------------------------------------------------
module pm4_queue
  import pm4_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign space      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/pm4_back.sv
// ---------------------------------------------------------------------------
// PM4 back end
// Checks register indices against the limit and holds the output word.
// ---------------------------------------------------------------------------
module pm4_back
  import pm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  input  logic [15:0] reg_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [14:0] reg_index,
  output logic [31:0] value,
  output logic [6:0]  opcode,
  output logic        predicated,
  output logic [13:0] payload_pos,
  output logic        last,
  output logic        bad_index
);

  logic bad;

  assign pop = head_valid && (!out_valid || out_ready);
  assign bad = (head_cmd.kind == KIND_REG) && (head_cmd.idx >= reg_limit);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind        <= head_cmd.kind;
      reg_index   <= head_cmd.idx[14:0];
      value       <= head_cmd.value;
      opcode      <= head_cmd.opcode;
      predicated  <= head_cmd.predicated;
      payload_pos <= head_cmd.pos;
      last        <= head_cmd.last;
      bad_index   <= bad;
    end
  end

endmodule
